[design/scr_pkg.sv]
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants for the secant cube root core
// Sequencer states, fixed field widths and saturation limits.
// ----------------------------------------------------------------------------
package scr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_STEPS     = 64;
   localparam int CNT_W         = 7;

   // residual clamp 2^61 and secant step clamp 2^40
   localparam logic [63:0] RES_CAP  = 64'h2000_0000_0000_0000;
   localparam logic [63:0] STEP_CAP = 64'h0000_0100_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_CUBE,
      ST_STEP,
      ST_SMUL,
      ST_SDIV,
      ST_UPD,
      ST_CDIV
   } state_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

endpackage

[design/secant_cube_root_core.sv]
// ----------------------------------------------------------------------------
// secant_cube_root_core: secant method cube root in signed fixed point
// Runs secant iterations on f(x) = x^3 - target with one shared
// add/subtract unit doing bit-serial multiplies and restoring divides.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one run request: target and two starting guesses.
//   rsp_* gives one result per iteration: index, estimate, change in
//   percent, a fault flag (tuser) and tlast on the final result of a run.
//   csr_wr_en/csr_wr_data set the iteration count (0 acts as 1, above 64
//   acts as 64); write it only while the core is idle. Reset value is 8.
// Sequence:
//   Multiplies and divides run through one 66-bit add/subtract unit, one bit
//   per cycle. A residual is a square multiply then a cube multiply. An
//   iteration is a step multiply, a step divide (skipped when the step
//   saturates), a change divide and the new residual, the last one without
//   the new residual; a run starts with the residuals of both guesses.
//   req_tready is high only between runs; one run at a time.
// Reset and stalls:
//   reset is synchronous; it returns the core to idle and drops rsp_tvalid.
//   A result sits in the output register until taken; if the next result
//   is ready before that transfer, the sequencer holds until the register
//   frees up. Nothing is dropped.
// ----------------------------------------------------------------------------
module secant_cube_root_core #(
   parameter int FRAC_BITS = scr_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // target_value[15:0], first_guess[47:16],
                                   // second_guess[79:48]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // iteration_index[6:0], estimate[38:7],
                                   // change_percent[70:39], zero pad[71]
   output logic        rsp_tuser,  // fault
   output logic        rsp_tlast
);

   scr_pkg::state_type state_ff, state_in;

   logic [6:0]          cnt_cfg_ff, cnt_cfg_in;
   logic [6:0]          runs_ff, runs_in;
   logic [6:0]          k_ff, k_in;
   logic signed [15:0]  tgt_ff, tgt_in;
   logic signed [31:0]  x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [63:0]  f0_ff, f0_in, f1_ff, f1_in;
   logic                fsel_ff, fsel_in;

   // shared unit registers
   logic [63:0] uhi_ff, uhi_in, ulo_ff, ulo_in, uop_ff, uop_in, umul_ff, umul_in;
   logic [6:0]  ucnt_ff, ucnt_in;

   // output register
   logic        ovld_ff, ovld_in;
   logic [6:0]  oidx_ff, oidx_in;
   logic [31:0] oest_ff, oest_in, ochg_ff, ochg_in;
   logic        oflt_ff, oflt_in, olast_ff, olast_in;

   // combinational helpers
   logic        unit_div, unit_run, unit_done, out_free;
   logic [65:0] add_x, add_y, add_sum;
   logic        add_cin, div_ge;
   logic [95:0] p96;
   logic [31:0] m_cur, m_x2;
   logic [63:0] sq_val, cube_mag;
   logic signed [64:0] cube_s, res_w;
   logic signed [63:0] res_v;
   logic signed [32:0] dx;
   logic signed [64:0] dy;
   logic [63:0] dy_mag, q_sat;
   logic        step_neg;
   logic signed [47:0] x2_w;
   logic signed [31:0] x2_sat;
   logic signed [32:0] dchg;
   logic [32:0] dchg_mag;
   logic [39:0] dchg_100;
   logic [6:0]  k_next;
   logic        fin;

   // ------------------------------------------------------------------
   // shared add/subtract unit: mul step adds, div step compares/subtracts
   // ------------------------------------------------------------------
   always_comb begin
      unit_div = (state_ff == scr_pkg::ST_SDIV) || (state_ff == scr_pkg::ST_CDIV);
      unit_run = ((state_ff == scr_pkg::ST_SQ) || (state_ff == scr_pkg::ST_CUBE) ||
                  (state_ff == scr_pkg::ST_SMUL) || unit_div) && (ucnt_ff != 7'd0);
      unit_done = (ucnt_ff == 7'd0);
      if (unit_div) begin
         add_x   = {1'b0, uhi_ff, ulo_ff[63]};
         add_y   = ~{2'b00, uop_ff};
         add_cin = 1'b1;
      end else begin
         add_x   = {2'b00, uhi_ff};
         add_y   = {2'b00, (umul_ff[0] ? uop_ff : 64'd0)};
         add_cin = 1'b0;
      end
      add_sum = add_x + add_y + 66'(add_cin);
      div_ge  = ~add_sum[65];
   end

   // ------------------------------------------------------------------
   // datapath values used by the sequencer
   // ------------------------------------------------------------------
   always_comb begin
      m_cur    = fsel_ff ? scr_pkg::mag32(x1_ff) : scr_pkg::mag32(x0_ff);
      m_x2     = scr_pkg::mag32(x2_ff);
      p96      = {uhi_ff, ulo_ff[63:32]};
      sq_val   = p96[63:0] >> FRAC_BITS;
      cube_mag = (p96[95:64] != 32'd0) ? scr_pkg::RES_CAP : (p96[63:0] >> FRAC_BITS);
      cube_s   = (fsel_ff ? x1_ff[31] : x0_ff[31]) ? -$signed({1'b0, cube_mag})
                                                   : $signed({1'b0, cube_mag});
      res_w    = cube_s - ($signed(65'(tgt_ff)) <<< FRAC_BITS);
      if (res_w > $signed({1'b0, scr_pkg::RES_CAP}))
         res_v = $signed(scr_pkg::RES_CAP);
      else if (res_w < -$signed({1'b0, scr_pkg::RES_CAP}))
         res_v = -$signed(scr_pkg::RES_CAP);
      else
         res_v = res_w[63:0];

      dx       = 33'(x1_ff) - 33'(x0_ff);
      dy       = 65'(f1_ff) - 65'(f0_ff);
      dy_mag   = scr_pkg::mag64(dy[63:0]);
      q_sat    = (ulo_ff > scr_pkg::STEP_CAP) ? scr_pkg::STEP_CAP : ulo_ff;
      step_neg = (dx[32] != f1_ff[63]) != dy[64];
      x2_w     = step_neg ? 48'(x1_ff) + $signed({7'd0, q_sat[40:0]})
                          : 48'(x1_ff) - $signed({7'd0, q_sat[40:0]});
      if (x2_w > 48'sh7FFF_FFFF)
         x2_sat = 32'sh7FFF_FFFF;
      else if (x2_w < -48'sh8000_0000)
         x2_sat = -32'sh8000_0000;
      else
         x2_sat = x2_w[31:0];

      dchg     = 33'(x2_sat) - 33'(x1_ff);
      dchg_mag = dchg[32] ? 33'(-dchg) : 33'(dchg);
      dchg_100 = (40'(dchg_mag) << 6) + (40'(dchg_mag) << 5) + (40'(dchg_mag) << 2);

      k_next   = k_ff + 7'd1;
      fin      = (k_next == runs_ff);
      out_free = ~ovld_ff | rsp_tready;
   end

   // ------------------------------------------------------------------
   // sequencer: next state, unit loads, state updates, result writes
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      cnt_cfg_in = csr_wr_en ? csr_wr_data : cnt_cfg_ff;
      runs_in    = runs_ff;
      k_in       = k_ff;
      tgt_in     = tgt_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      x2_in      = x2_ff;
      f0_in      = f0_ff;
      f1_in      = f1_ff;
      fsel_in    = fsel_ff;
      uhi_in     = uhi_ff;
      ulo_in     = ulo_ff;
      uop_in     = uop_ff;
      umul_in    = umul_ff;
      ucnt_in    = ucnt_ff;
      ovld_in    = ovld_ff & ~rsp_tready;
      oidx_in    = oidx_ff;
      oest_in    = oest_ff;
      ochg_in    = ochg_ff;
      oflt_in    = oflt_ff;
      olast_in   = olast_ff;
      req_tready = (state_ff == scr_pkg::ST_IDLE);

      // one unit step per cycle while a count is pending
      if (unit_run) begin
         ucnt_in = ucnt_ff - 7'd1;
         if (unit_div) begin
            uhi_in = div_ge ? add_sum[63:0] : {uhi_ff[62:0], ulo_ff[63]};
            ulo_in = {ulo_ff[62:0], div_ge};
         end else begin
            uhi_in  = add_sum[64:1];
            ulo_in  = {add_sum[0], ulo_ff[63:1]};
            umul_in = umul_ff >> 1;
         end
      end

      case (state_ff)
         scr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               tgt_in  = req_tdata[15:0];
               x0_in   = req_tdata[47:16];
               x1_in   = req_tdata[79:48];
               k_in    = 7'd0;
               fsel_in = 1'b0;
               if (cnt_cfg_ff == 7'd0)
                  runs_in = 7'd1;
               else if (cnt_cfg_ff > 7'(scr_pkg::MAX_STEPS))
                  runs_in = 7'(scr_pkg::MAX_STEPS);
               else
                  runs_in = cnt_cfg_ff;
               uhi_in   = 64'd0;
               ulo_in   = 64'd0;
               uop_in   = 64'(scr_pkg::mag32(req_tdata[47:16]));
               umul_in  = 64'(scr_pkg::mag32(req_tdata[47:16]));
               ucnt_in  = 7'd32;
               state_in = scr_pkg::ST_SQ;
            end
         end
         scr_pkg::ST_SQ: begin
            if (unit_done) begin
               uhi_in   = 64'd0;
               ulo_in   = 64'd0;
               uop_in   = sq_val;
               umul_in  = 64'(m_cur);
               ucnt_in  = 7'd32;
               state_in = scr_pkg::ST_CUBE;
            end
         end
         scr_pkg::ST_CUBE: begin
            if (unit_done) begin
               if (!fsel_ff) begin
                  f0_in    = res_v;
                  fsel_in  = 1'b1;
                  uhi_in   = 64'd0;
                  ulo_in   = 64'd0;
                  uop_in   = 64'(scr_pkg::mag32(x1_ff));
                  umul_in  = 64'(scr_pkg::mag32(x1_ff));
                  ucnt_in  = 7'd32;
                  state_in = scr_pkg::ST_SQ;
               end else begin
                  f1_in    = res_v;
                  state_in = scr_pkg::ST_STEP;
               end
            end
         end
         scr_pkg::ST_STEP: begin
            if (dy == 65'sd0) begin
               // zero denominator: fault result, run ends
               if (out_free) begin
                  ovld_in  = 1'b1;
                  oidx_in  = k_next;
                  oest_in  = x1_ff;
                  ochg_in  = 32'd0;
                  oflt_in  = 1'b1;
                  olast_in = 1'b1;
                  state_in = scr_pkg::ST_IDLE;
               end
            end else begin
               uhi_in   = 64'd0;
               ulo_in   = 64'd0;
               uop_in   = scr_pkg::mag64(f1_ff);
               umul_in  = 64'(dx[32] ? 33'(-dx) : 33'(dx));
               ucnt_in  = 7'd64;
               state_in = scr_pkg::ST_SMUL;
            end
         end
         scr_pkg::ST_SMUL: begin
            if (unit_done) begin
               if (uhi_ff >= dy_mag) begin
                  ulo_in   = scr_pkg::STEP_CAP;
                  state_in = scr_pkg::ST_UPD;
               end else begin
                  uop_in   = dy_mag;
                  ucnt_in  = 7'd64;
                  state_in = scr_pkg::ST_SDIV;
               end
            end
         end
         scr_pkg::ST_SDIV: begin
            if (unit_done)
               state_in = scr_pkg::ST_UPD;
         end
         scr_pkg::ST_UPD: begin
            if (x2_sat == 32'sd0) begin
               // estimate collapsed to zero: fault result, run ends
               if (out_free) begin
                  ovld_in  = 1'b1;
                  oidx_in  = k_next;
                  oest_in  = 32'd0;
                  ochg_in  = 32'd0;
                  oflt_in  = 1'b1;
                  olast_in = 1'b1;
                  state_in = scr_pkg::ST_IDLE;
               end
            end else begin
               x2_in    = x2_sat;
               uhi_in   = 64'd0;
               ulo_in   = 64'(dchg_100) << FRAC_BITS;
               uop_in   = 64'(scr_pkg::mag32(x2_sat));
               ucnt_in  = 7'd64;
               state_in = scr_pkg::ST_CDIV;
            end
         end
         scr_pkg::ST_CDIV: begin
            if (unit_done && out_free) begin
               ovld_in  = 1'b1;
               oidx_in  = k_next;
               oest_in  = x2_ff;
               ochg_in  = (ulo_ff[63:32] != 32'd0) ? 32'hFFFF_FFFF : ulo_ff[31:0];
               oflt_in  = 1'b0;
               olast_in = fin;
               k_in     = k_next;
               x0_in    = x1_ff;
               x1_in    = x2_ff;
               f0_in    = f1_ff;
               if (fin) begin
                  state_in = scr_pkg::ST_IDLE;
               end else begin
                  // residual of the new estimate
                  fsel_in  = 1'b1;
                  uhi_in   = 64'd0;
                  ulo_in   = 64'd0;
                  uop_in   = 64'(m_x2);
                  umul_in  = 64'(m_x2);
                  ucnt_in  = 7'd32;
                  state_in = scr_pkg::ST_SQ;
               end
            end
         end
         default: state_in = scr_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= scr_pkg::ST_IDLE;
         cnt_cfg_ff <= 7'd8;
         runs_ff    <= 7'd1;
         k_ff       <= 7'd0;
         ucnt_ff    <= 7'd0;
         ovld_ff    <= 1'b0;
         fsel_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_cfg_ff <= cnt_cfg_in;
         runs_ff    <= runs_in;
         k_ff       <= k_in;
         ucnt_ff    <= ucnt_in;
         ovld_ff    <= ovld_in;
         fsel_ff    <= fsel_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_ff   <= tgt_in;
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      x2_ff    <= x2_in;
      f0_ff    <= f0_in;
      f1_ff    <= f1_in;
      uhi_ff   <= uhi_in;
      ulo_ff   <= ulo_in;
      uop_ff   <= uop_in;
      umul_ff  <= umul_in;
      oidx_ff  <= oidx_in;
      oest_ff  <= oest_in;
      ochg_ff  <= ochg_in;
      oflt_ff  <= oflt_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {1'b0, ochg_ff, oest_ff, oidx_ff};
   assign rsp_tuser  = oflt_ff;
   assign rsp_tlast  = olast_ff;

   // assertions
   a_fault_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("fault result without tlast");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == scr_pkg::ST_IDLE)
      else $error("request taken outside idle");
   a_unit_count: assert property (@(posedge clock) disable iff (reset)
      ucnt_ff <= 7'd64)
      else $error("unit count out of range");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != scr_pkg::ST_IDLE |-> k_ff < runs_ff)
      else $error("iteration count overrun");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] != 7'd0 && rsp_tdata[6:0] <= 7'd64)
      else $error("result index out of range");

endmodule
